/* rtl/patpmb_pkg.sv */
// Package for the PAT section program map builder.
// Holds sizes, codes, the controller state type and the search token type.
// No dependencies; every other file of the block imports it.
package patpmb_pkg;

  localparam int TABLE_DEPTH       = 64;
  localparam int MAX_SECTION_BYTES = 4096;

  localparam int HEADER_BYTES  = 8;
  localparam int SECNUM_INDEX  = 6;
  localparam int TSID_HI_INDEX = 3;
  localparam int TSID_LO_INDEX = 4;
  localparam int ENTRY_BYTES   = 4;
  localparam int ENTRY_SH      = $clog2(ENTRY_BYTES);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BIDX_W = $clog2(MAX_SECTION_BYTES + 1);
  localparam int MAXP_W = 7;

  localparam int PNUM_W = 16;
  localparam int PID_W  = 13;
  localparam int TSID_W = 16;

  localparam int OUT_DATA_W = 72;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARSE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Lookup token that walks the row of table cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CNT_W-1:0]  remain;
    logic [PNUM_W-1:0] key;
  } token_t;

endpackage

/* rtl/patpmb_cell.sv */
// One program table cell: holds one program number and checks the passing token.
// Depends on patpmb_pkg.
module patpmb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  patpmb_pkg::token_t        tok_i,
  output patpmb_pkg::token_t        tok_o,
  input  logic                      wr_en,
  input  logic [patpmb_pkg::PNUM_W-1:0] wr_num
);
  import patpmb_pkg::*;

  logic [PNUM_W-1:0] num_r;
  token_t            tok_r;
  logic              live;

  // Only cells below the fill count take part; the token counts them down.
  assign live = tok_i.valid && (tok_i.remain != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      num_r <= wr_num;
    end
  end

  // Only the valid bit is reset; the other token fields are don't-care while
  // it is low.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_i.valid;
    end
    tok_r.key    <= tok_i.key;
    tok_r.hit    <= tok_i.hit | (live && (num_r == tok_i.key));
    tok_r.remain <= live ? tok_i.remain - CNT_W'(1) : tok_i.remain;
  end

  assign tok_o = tok_r;

endmodule

/* rtl/patpmb_chain.sv */
// Row of program table cells that a lookup token walks through.
// Depends on patpmb_pkg and patpmb_cell.
module patpmb_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  patpmb_pkg::token_t            tok_i,
  output patpmb_pkg::token_t            tok_o,
  input  logic                          wr_en,
  input  logic [patpmb_pkg::IDX_W-1:0]  wr_idx,
  input  logic [patpmb_pkg::PNUM_W-1:0] wr_num
);
  import patpmb_pkg::*;

  token_t tok [TABLE_DEPTH+1];

  assign tok[0] = tok_i;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic sel;
    assign sel = wr_en && (wr_idx == IDX_W'(g));
    patpmb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .wr_en  (sel),
      .wr_num (wr_num)
    );
  end

  assign tok_o = tok[TABLE_DEPTH];

endmodule

/* rtl/pat_section_program_map_builder.sv */
// Top level of the PAT section program map builder.
// Depends on patpmb_pkg and patpmb_chain (which instantiates patpmb_cell).
//
// Usage: section bytes arrive as beats on the in_ channel, in_tuser set, with
// in_tlast on the final byte of a section; a beat with in_tuser clear empties
// the program table and abandons the section in progress. The out_ channel
// carries one beat for each newly stored program and one end-of-section beat
// for every in_tlast byte, which also carries a program stored on that byte.
// The cfg_ port writes the table limit and may be used only while the block is idle.
// Timing: a byte is accepted in the idle state and parsed in the parse state;
// a byte that ends a section then passes through the emit state. At every
// fourth byte past the header, unless parsing has stopped, a held entry with a
// nonzero program number is looked up: a token walks the row of TABLE_DEPTH
// table cells, one cell per cycle, before the next beat is accepted, and a
// lookup that stores a program or ends a section then passes through the emit
// state, which writes the result into the output register.
// Reset: the table is empty, stream id and NIT PID are zero, the limit is 64.
// Stall: a result waits in the output register while out_tready is low; the
// next byte is still accepted and parsed, and the block holds only when it
// has a second result to deliver.
module pat_section_program_map_builder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: data_byte [7:0]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,
  // in_tuser: operation [0]
  input  logic                                  in_tuser,
  input  logic                                  in_tlast,
  // out_tdata: prog_num [15:0], pmt_pid [28:16], status [29],
  //            transport_stream_id [45:30], network_pid [58:46],
  //            program_count [65:59], zero fill [71:66]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [patpmb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: result_kind [0]
  output logic                                  out_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [patpmb_pkg::MAXP_W-1:0]         cfg_wr_data
);
  import patpmb_pkg::*;

  state_t state_r, state_nxt;

  // Latched input beat.
  logic              op_r, op_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;

  // Section parsing state.
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic [31:0]       shift_r, shift_nxt;
  logic [TSID_W-1:0] hold_r, hold_nxt;
  logic              stopped_r, stopped_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TSID_W-1:0] tsid_r, tsid_nxt;
  logic [PID_W-1:0]  nit_r, nit_nxt;
  logic [MAXP_W-1:0] maxp_r;

  // Candidate entry under lookup.
  logic [PNUM_W-1:0] cand_num_r, cand_num_nxt;
  logic [PID_W-1:0]  cand_pid_r, cand_pid_nxt;
  logic              stored_r, stored_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_kind_r, out_kind_nxt;

  logic             in_acc;
  logic             out_free;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic             in_range;
  logic             entry_due;
  logic             launch;
  logic             store_now;
  logic             wr_en;
  token_t           tok_head;
  token_t           tok_tail;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // The effective limit is the smaller of the register and the table depth.
  always_comb begin
    if (32'(maxp_r) < 32'(TABLE_DEPTH)) begin
      limit = CNT_W'(maxp_r);
    end else begin
      limit = CNT_W'(TABLE_DEPTH);
    end
  end

  assign cnt_inc = cnt_r + CNT_W'(1);

  // An entry is complete when the byte after its fourth byte arrives, so the
  // trailing CRC is never taken as an entry.
  assign in_range  = (bidx_r < BIDX_W'(MAX_SECTION_BYTES));
  assign entry_due = (state_r == ST_PARSE) && (op_r == OP_BYTE) && in_range &&
                     !stopped_r &&
                     (bidx_r >= BIDX_W'(HEADER_BYTES + ENTRY_BYTES)) &&
                     (bidx_r[ENTRY_SH-1:0] == '0);
  assign launch    = entry_due && (shift_r[31:16] != '0);

  assign store_now = (state_r == ST_SCAN) && tok_tail.valid && !tok_tail.hit &&
                     (cnt_r < limit);
  assign wr_en     = store_now;

  assign tok_head.valid  = launch;
  assign tok_head.hit    = 1'b0;
  assign tok_head.remain = cnt_r;
  assign tok_head.key    = shift_r[31:16];

  patpmb_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok_i  (tok_head),
    .tok_o  (tok_tail),
    .wr_en  (wr_en),
    .wr_idx (cnt_r[IDX_W-1:0]),
    .wr_num (cand_num_r)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (op_r == OP_CLEAR) begin
          state_nxt = ST_IDLE;
        end else if (launch) begin
          state_nxt = ST_SCAN;
        end else if (last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tok_tail.valid) begin
          state_nxt = (last_r || store_now) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output values.
  always_comb begin
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    bidx_nxt      = bidx_r;
    shift_nxt     = shift_r;
    hold_nxt      = hold_r;
    stopped_nxt   = stopped_r;
    cnt_nxt       = cnt_r;
    tsid_nxt      = tsid_r;
    nit_nxt       = nit_r;
    cand_num_nxt  = cand_num_r;
    cand_pid_nxt  = cand_pid_r;
    stored_nxt    = stored_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_tuser;
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
        end
      end
      ST_PARSE: begin
        if (op_r == OP_CLEAR) begin
          cnt_nxt     = '0;
          bidx_nxt    = '0;
          shift_nxt   = '0;
          hold_nxt    = '0;
          stopped_nxt = 1'b0;
        end else begin
          stored_nxt   = 1'b0;
          cand_num_nxt = shift_r[31:16];
          cand_pid_nxt = shift_r[PID_W-1:0];
          // Program number zero names the network PID.
          if (entry_due && !launch) begin
            nit_nxt = shift_r[PID_W-1:0];
          end
          if (in_range) begin
            if (bidx_r == BIDX_W'(TSID_HI_INDEX)) begin
              hold_nxt = {byte_r, hold_r[7:0]};
            end else if (bidx_r == BIDX_W'(TSID_LO_INDEX)) begin
              hold_nxt = {hold_r[15:8], byte_r};
            end else if ((bidx_r == BIDX_W'(SECNUM_INDEX)) && (byte_r == 8'd0)) begin
              tsid_nxt = hold_r;
            end
            if (bidx_r >= BIDX_W'(HEADER_BYTES)) begin
              shift_nxt = {shift_r[23:0], byte_r};
            end
            bidx_nxt = bidx_r + BIDX_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (tok_tail.valid && !tok_tail.hit) begin
          if (cnt_r >= limit) begin
            stopped_nxt = 1'b1;
          end else begin
            cnt_nxt    = cnt_inc;
            stored_nxt = 1'b1;
            if (cnt_inc >= limit) begin
              stopped_nxt = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = last_r ? KIND_END : KIND_STORE;
          out_data_nxt  = {6'd0, cnt_r, nit_r, tsid_r, stopped_r,
                           stored_r ? cand_pid_r : PID_W'(0),
                           stored_r ? cand_num_r : PNUM_W'(0)};
          if (last_r) begin
            bidx_nxt    = '0;
            shift_nxt   = '0;
            hold_nxt    = '0;
            stopped_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bidx_r      <= '0;
      shift_r     <= '0;
      hold_r      <= '0;
      stopped_r   <= 1'b0;
      cnt_r       <= '0;
      tsid_r      <= '0;
      nit_r       <= '0;
      maxp_r      <= MAXP_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bidx_r      <= bidx_nxt;
      shift_r     <= shift_nxt;
      hold_r      <= hold_nxt;
      stopped_r   <= stopped_nxt;
      cnt_r       <= cnt_nxt;
      tsid_r      <= tsid_nxt;
      nit_r       <= nit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        maxp_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    cand_num_r <= cand_num_nxt;
    cand_pid_r <= cand_pid_nxt;
    stored_r   <= stored_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // A lookup token leaves the cell row only while the controller waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_tail.valid |-> (state_r == ST_SCAN))
    else $error("lookup token left the cell row outside a scan");

  // The fill count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("program count beyond table depth");

  // A store adds exactly one program to the table.
  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    store_now |=> (cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1))))
    else $error("store did not advance the program count");

  // A stored-program beat never carries the reserved program number zero.
  a_store_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_STORE)) |-> (out_tdata[15:0] != 16'd0))
    else $error("stored program with number zero");

endmodule

/* verif/pat_table_tracker_pkg.sv */
// Prediction and checking for the PAT section program map builder testbench.
// Holds the expected report type and a small class that tracks the program table.
// Depends on patpmb_pkg for the sizes and the operation and result kind codes.
package pat_table_tracker_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import patpmb_pkg::*;

  typedef struct {
    logic              kind;
    logic [PNUM_W-1:0] prog;
    logic [PID_W-1:0]  pid;
    logic              halted;
    logic [TSID_W-1:0] tsid;
    logic [PID_W-1:0]  nit;
    logic [MAXP_W-1:0] count;
  } pat_report_t;

  class pat_table_tracker;
    logic [PNUM_W-1:0] prog_tbl[TABLE_DEPTH];
    logic [PID_W-1:0]  pid_tbl[TABLE_DEPTH];
    int unsigned       fill;
    logic [TSID_W-1:0] ts_id;
    logic [PID_W-1:0]  nit_pid;
    int unsigned       byte_pos;
    logic [31:0]       window;
    logic [TSID_W-1:0] tsid_hold;
    bit                halted;
    logic [MAXP_W-1:0] limit;
    pat_report_t       due_reports[$];
    int                errors;

    function new();
      fill    = 0;
      ts_id   = '0;
      nit_pid = '0;
      limit   = 7'd64;
      errors  = 0;
      clear_section();
    endfunction

    function void clear_section();
      byte_pos  = 0;
      window    = '0;
      tsid_hold = '0;
      halted    = 1'b0;
    endfunction

    // Applies one accepted input beat and queues the report it causes, if any.
    function void note_beat(logic op, logic [7:0] b, logic last);
      logic [PNUM_W-1:0] num;
      logic [PID_W-1:0]  pidv;
      logic [PNUM_W-1:0] pn;
      logic [PID_W-1:0]  pd;
      bit                stored;
      bit                dup;
      int unsigned       j;
      int unsigned       lim;
      pat_report_t       rep;

      stored = 1'b0;
      pn     = '0;
      pd     = '0;
      j      = byte_pos;
      lim    = (limit < TABLE_DEPTH) ? limit : TABLE_DEPTH;

      if (op == OP_CLEAR) begin
        fill = 0;
        clear_section();
        return;
      end

      if (j < MAX_SECTION_BYTES) begin
        // The held entry is parsed only once a following byte shows up.
        if (!halted && j >= HEADER_BYTES + ENTRY_BYTES &&
            ((j - HEADER_BYTES) % ENTRY_BYTES) == 0) begin
          num  = window[31:16];
          pidv = window[PID_W-1:0];
          if (num == 0) begin
            nit_pid = pidv;
          end else begin
            dup = 1'b0;
            for (int k = 0; k < fill; k++) begin
              if (prog_tbl[k] == num) dup = 1'b1;
            end
            if (!dup) begin
              if (fill >= lim) begin
                halted = 1'b1;
              end else begin
                prog_tbl[fill] = num;
                pid_tbl[fill]  = pidv;
                fill++;
                if (fill >= lim) halted = 1'b1;
                stored = 1'b1;
                pn     = num;
                pd     = pidv;
              end
            end
          end
        end
        if (j == TSID_HI_INDEX) begin
          tsid_hold[15:8] = b;
        end else if (j == TSID_LO_INDEX) begin
          tsid_hold[7:0] = b;
        end else if (j == SECNUM_INDEX && b == 8'h00) begin
          ts_id = tsid_hold;
        end
        if (j >= HEADER_BYTES) window = {window[23:0], b};
        byte_pos = j + 1;
      end

      if (!last && !stored) return;

      rep.kind   = last ? KIND_END : KIND_STORE;
      rep.prog   = pn;
      rep.pid    = pd;
      rep.halted = halted;
      rep.tsid   = ts_id;
      rep.nit    = nit_pid;
      rep.count  = fill[MAXP_W-1:0];
      due_reports.push_back(rep);
      if (last) clear_section();
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
      end
    endfunction

    function void check_report(logic kind, logic [OUT_DATA_W-1:0] d);
      pat_report_t want;

      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected, kind %0d data 0x%0h",
                 $time, kind, d);
        return;
      end
      want = due_reports.pop_front();
      compare("result_kind", 32'(want.kind), 32'(kind));
      compare("prog_num", 32'(want.prog), 32'(d[15:0]));
      compare("pmt_pid", 32'(want.pid), 32'(d[28:16]));
      compare("status", 32'(want.halted), 32'(d[29]));
      compare("transport_stream_id", 32'(want.tsid), 32'(d[45:30]));
      compare("network_pid", 32'(want.nit), 32'(d[58:46]));
      compare("program_count", 32'(want.count), 32'(d[65:59]));
    endfunction
  endclass

endpackage

/* verif/pat_section_program_map_builder_tb.sv */
// Self-checking testbench for the PAT section program map builder.
// Depends on patpmb_pkg, pat_table_tracker_pkg and the block's RTL.
module pat_section_program_map_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import patpmb_pkg::*;
  import pat_table_tracker_pkg::*;

  typedef logic [7:0]  byte_q_t[$];
  typedef logic [15:0] word_q_t[$];

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;
  logic                  in_tuser    = OP_BYTE;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en   = 1'b0;
  logic [MAXP_W-1:0]     cfg_wr_data = '0;

  pat_table_tracker tracker;

  // Per-section switches that turn off idling on one side, and the request
  // for one long receiver hold-off.
  bit quiet_src;
  bit quiet_sink;
  bit hold_req;
  int beats_sent;

  always #4 clk = ~clk;

  pat_section_program_map_builder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat and returns at the edge where it is accepted. Valid is
  // left high so that a following beat without a gap goes out back to back.
  task automatic send_beat(input logic op, input logic [7:0] b, input logic last);
    int gap;
    gap = quiet_src ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_beat(op, b, last);
    beats_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_beat(OP_BYTE, q[i], i == q.size() - 1);
  endtask

  // Random bytes with no structure; the final one optionally ends the section.
  task automatic raw_section(input int len, input bit with_end);
    for (int k = 0; k < len; k++) begin
      send_beat(OP_BYTE, 8'($urandom_range(0, 255)), with_end && k == len - 1);
    end
  endtask

  // Builds a section: eight header bytes with the given stream id and section
  // number, one 4-byte entry per program, then crc_len trailing bytes. The top
  // three bits of each PID word are random and must be dropped by the block.
  function automatic byte_q_t build_pat(input logic [15:0] tsid,
                                        input logic [7:0] secnum,
                                        input word_q_t nums,
                                        input word_q_t pids,
                                        input int crc_len);
    byte_q_t q;
    for (int k = 0; k < HEADER_BYTES; k++) q.push_back(8'($urandom_range(0, 255)));
    q[TSID_HI_INDEX] = tsid[15:8];
    q[TSID_LO_INDEX] = tsid[7:0];
    q[SECNUM_INDEX]  = secnum;
    foreach (nums[k]) begin
      q.push_back(nums[k][15:8]);
      q.push_back(nums[k][7:0]);
      q.push_back(pids[k][15:8]);
      q.push_back(pids[k][7:0]);
    end
    repeat (crc_len) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // A section of n distinct programs numbered from base, with random PIDs.
  task automatic fill_section(input int n, input logic [15:0] base, input int crc_len);
    word_q_t nums;
    word_q_t pids;
    for (int k = 0; k < n; k++) begin
      nums.push_back(base + 16'(k));
      pids.push_back(16'($urandom_range(0, 65535)));
    end
    send_bytes(build_pat(16'($urandom_range(0, 65535)), 8'h00, nums, pids, crc_len));
  endtask

  // Drops valid, waits for every expected report, then waits out a full table
  // lookup since clears and plain bytes leave no report to wait for.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAXP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.limit = v;
  endtask

  // Mostly well-formed sections with random content: a mix of new programs,
  // repeats of stored ones and NIT entries. The rest are clears and truncated
  // or unstructured byte runs.
  task automatic random_section();
    int      r;
    int      n;
    int      crc_len;
    int      c;
    bit      with_end;
    word_q_t nums;
    word_q_t pids;

    quiet_src  = ($urandom_range(0, 4) == 0);
    quiet_sink = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (r < 20) begin
      with_end = 1'($urandom_range(0, 1));
      raw_section($urandom_range(1, 24), with_end);
      if (!with_end && $urandom_range(0, 1)) begin
        send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        c = $urandom_range(0, 99);
        if (c < 10) begin
          nums.push_back(16'h0000);
        end else if (c < 45 && tracker.fill > 0) begin
          nums.push_back(tracker.prog_tbl[$urandom_range(0, tracker.fill - 1)]);
        end else begin
          nums.push_back(16'($urandom_range(1, 65535)));
        end
        pids.push_back(16'($urandom_range(0, 65535)));
      end
      crc_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : ENTRY_BYTES;
      send_bytes(build_pat(16'($urandom_range(0, 65535)),
                           $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)),
                           nums, pids, crc_len));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request so that the
  // output register and the block behind it fill up and in_tready drops.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        gap = quiet_sink ? 0 : pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every result beat is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      tracker.check_report(out_tuser, out_tdata);
    end
  end

  initial begin
    word_q_t           nums;
    word_q_t           pids;
    logic [MAXP_W-1:0] limits[6];
    int                target;

    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the limit at its reset value. A clear on an empty
    // table, then sections too short to reach any entry.
    send_beat(OP_CLEAR, 8'hFF, 1'b1);
    send_beat(OP_BYTE, 8'h00, 1'b1);
    raw_section(5, 1'b1);

    // Extremes: stream id all ones captured from section zero, a NIT entry
    // with an all-ones PID, the largest and smallest program numbers, and a
    // repeat of a program that is already stored.
    nums = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF};
    pids = '{16'hFFFF, 16'hE000, 16'h0000, 16'h1234};
    send_bytes(build_pat(16'hFFFF, 8'h00, nums, pids, ENTRY_BYTES));

    // A nonzero section number keeps the old stream id. The entry is parsed on
    // the byte that ends the section, so the end report carries the store.
    nums = '{16'h8000};
    pids = '{16'h1FFF};
    send_bytes(build_pat(16'h1234, 8'hFF, nums, pids, 1));

    // Stream id zero captured, NIT PID back to zero.
    nums = '{16'h0000};
    pids = '{16'h0000};
    send_bytes(build_pat(16'h0000, 8'h00, nums, pids, ENTRY_BYTES));

    // A clear in the middle of a section abandons it; the program stored
    // earlier counts as new again afterwards.
    raw_section(10, 1'b0);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    nums = '{16'h8000};
    pids = '{16'hA5A5};
    send_bytes(build_pat(16'h5A5A, 8'h00, nums, pids, ENTRY_BYTES));
    settle();

    // Table full at a small limit: three stores, then parsing stops.
    write_limit(7'd3);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    fill_section(5, 16'h0100, ENTRY_BYTES);
    settle();

    // A limit of zero stores nothing.
    write_limit(7'd0);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    fill_section(2, 16'h0200, ENTRY_BYTES);
    settle();

    // A limit above the table depth is held to the depth.
    write_limit(7'd127);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    fill_section(TABLE_DEPTH + 2, 16'h0300, ENTRY_BYTES);
    settle();

    // Overlong section of NIT entries only: the NIT PID in the end report
    // shows which entry was the last one parsed below the byte limit.
    write_limit(7'd64);
    send_beat(OP_CLEAR, 8'h00, 1'b0);
    nums = {};
    pids = {};
    for (int k = 0; k < MAX_SECTION_BYTES / ENTRY_BYTES + 1; k++) begin
      nums.push_back(16'h0000);
      pids.push_back(16'($urandom_range(0, 65535)));
    end
    send_bytes(build_pat(16'($urandom_range(0, 65535)), 8'h00, nums, pids, 2));
    settle();

    // Random phases, each under its own limit. The first one starts from an
    // empty table and asks the receiver for its long hold-off.
    limits = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd0};
    limits[3] = MAXP_W'($urandom_range(1, TABLE_DEPTH));
    limits[5] = MAXP_W'($urandom_range(0, 127));
    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 0) begin
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        hold_req = 1'b1;
      end
      target = beats_sent + 117;
      while (beats_sent < target) random_section();
      quiet_src  = 1'b0;
      quiet_sink = 1'b0;
      settle();
    end

    if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
      $display("pat_section_program_map_builder test passed");
    end else begin
      $display("pat_section_program_map_builder test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #40_000_000;
    $display("pat_section_program_map_builder test failed");
    $finish;
  end

endmodule
